// ===== rtl/length_prefixed_message_type_counter_macros.svh =====
// Assertion macros for the length-prefixed message type counter.
`ifndef LENGTH_PREFIXED_MESSAGE_TYPE_COUNTER_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_TYPE_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define LPMTC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lpmtc same-cycle check failed");
// Next-cycle implication, disabled during reset
`define LPMTC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lpmtc next-cycle check failed");
`else
`define LPMTC_ASSERT_IMPLY(label, clk, rst, a, b)
`define LPMTC_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== rtl/lpmtc_pkg.sv =====
// Shared types, constants and helpers of the message type counter.
package lpmtc_pkg;

  localparam int COUNT_BITS = 40;
  localparam int NUM_CLS    = 5;
  localparam int STATUS_BITS = 2;
  localparam int OUT_BITS   = ((6 * COUNT_BITS + STATUS_BITS + 7) / 8) * 8;

  // Message type bytes
  localparam logic [7:0] TYPE_ADD     = 8'h41;  // 'A'
  localparam logic [7:0] TYPE_ADD_ALT = 8'h46;  // 'F'
  localparam logic [7:0] TYPE_DELETE  = 8'h44;  // 'D'
  localparam logic [7:0] TYPE_CANCEL  = 8'h58;  // 'X'
  localparam logic [7:0] TYPE_REPLACE = 8'h55;  // 'U'

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_ADD     = 3'd0,
    CLS_DELETE  = 3'd1,
    CLS_CANCEL  = 3'd2,
    CLS_REPLACE = 3'd3,
    CLS_UNKNOWN = 3'd4
  } cls_t;

  // One request from the parser to the counting side
  typedef struct packed {
    logic    count_en;
    cls_t    cls;
    logic    last;
    status_t status;
  } event_t;

  function automatic cls_t classify(input logic [7:0] t);
    cls_t c;
    case (t)
      TYPE_ADD, TYPE_ADD_ALT: c = CLS_ADD;
      TYPE_DELETE:            c = CLS_DELETE;
      TYPE_CANCEL:            c = CLS_CANCEL;
      TYPE_REPLACE:           c = CLS_REPLACE;
      default:                c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
                                                     input logic en);
    logic [COUNT_BITS-1:0] r;
    r = (en && (c != '1)) ? c + COUNT_BITS'(1) : c;
    return r;
  endfunction

endpackage

// ===== rtl/lpmtc_front.sv =====
// Frame parser: tracks length prefixes and emits count and end-of-stream requests.
module lpmtc_front import lpmtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  input  logic       q_full,
  output logic       ev_push,
  output event_t     ev
);

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_SKIP,
    PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] body_remaining, body_remaining_next;
  logic [7:0]  pending_type, pending_type_next;
  status_t     error_status, error_status_next;
  logic        count_en;
  logic [7:0]  type_now;
  logic        accept;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  // Work out the parser step for the offered byte
  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    body_remaining_next = body_remaining;
    pending_type_next   = pending_type;
    error_status_next   = error_status;
    count_en            = 1'b0;
    type_now            = (phase == PH_TYPE) ? data_byte : pending_type;
    case (phase)
      PH_LEN_HI: begin
        length_high_next = data_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        body_remaining_next = {length_high, data_byte};
        if ({length_high, data_byte} == 16'd0) begin
          error_status_next = ST_ZERO_LEN;
          phase_next        = PH_HALT;
        end else begin
          phase_next = PH_TYPE;
          if (stream_end) error_status_next = ST_TRUNCATED;
        end
      end
      PH_TYPE, PH_SKIP: begin
        pending_type_next   = type_now;
        body_remaining_next = body_remaining - 16'd1;
        if (body_remaining == 16'd1) begin
          count_en   = 1'b1;
          phase_next = PH_LEN_HI;
        end else begin
          phase_next = PH_SKIP;
          if (stream_end) error_status_next = ST_TRUNCATED;
        end
      end
      default: ;
    endcase
  end

  // Build the request for the queue
  assign ev_push     = accept && (count_en || stream_end);
  assign ev.count_en = count_en;
  assign ev.cls      = classify(type_now);
  assign ev.last     = stream_end;
  assign ev.status   = error_status_next;

  // Advance parser state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN_HI;
      length_high    <= '0;
      body_remaining <= '0;
      pending_type   <= '0;
      error_status   <= ST_OK;
    end else if (accept) begin
      if (stream_end) begin
        phase          <= PH_LEN_HI;
        length_high    <= '0;
        body_remaining <= '0;
        pending_type   <= '0;
        error_status   <= ST_OK;
      end else begin
        phase          <= phase_next;
        length_high    <= length_high_next;
        body_remaining <= body_remaining_next;
        pending_type   <= pending_type_next;
        error_status   <= error_status_next;
      end
    end
  end

endmodule

// ===== rtl/lpmtc_queue.sv =====
// Two-entry request queue between parser and counters.
module lpmtc_queue import lpmtc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_ev,
  output logic   full,
  output logic   q_valid,
  input  logic   pop,
  output event_t pop_ev
);

  event_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign pop_ev  = slots[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_ev;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/lpmtc_back.sv =====
// Saturating counters and the result output register.
module lpmtc_back import lpmtc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  event_t              ev,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_data
);

  logic [COUNT_BITS-1:0] total, total_next;
  logic [COUNT_BITS-1:0] cnt [NUM_CLS];
  logic [COUNT_BITS-1:0] cnt_next [NUM_CLS];
  logic [OUT_BITS-1:0]   word;

  // Take a request unless it is final and the output still holds a result
  assign pop = q_valid && !(ev.last && out_valid && !out_ready);

  // Count the request into the total and its matching class
  always_comb begin
    total_next = sat_inc(total, ev.count_en);
    for (int i = 0; i < NUM_CLS; i++) begin
      cnt_next[i] = sat_inc(cnt[i], ev.count_en && (ev.cls == cls_t'(3'(i))));
    end
  end

  // Pack the result: total, then class counts, then status
  always_comb begin
    word = '0;
    word[COUNT_BITS-1:0] = total_next;
    for (int i = 0; i < NUM_CLS; i++) begin
      word[(i + 1) * COUNT_BITS +: COUNT_BITS] = cnt_next[i];
    end
    word[6 * COUNT_BITS +: STATUS_BITS] = ev.status;
  end

  // Hold counters; clear them once a result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_CLS; i++) cnt[i] <= '0;
    end else if (pop) begin
      if (ev.last) begin
        total <= '0;
        for (int i = 0; i < NUM_CLS; i++) cnt[i] <= '0;
      end else begin
        total <= total_next;
        for (int i = 0; i < NUM_CLS; i++) cnt[i] <= cnt_next[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && ev.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ev.last) out_data <= word;
  end

endmodule

// ===== rtl/length_prefixed_message_type_counter.sv =====
// A result passes through the request queue and then the output register.
// Throughput: one byte per cycle; the parser only stalls when its two-entry
// request queue fills, which happens while an unread result blocks the output.
// Reset: synchronous active-high rst clears parser, queue, counters and the
// output valid; the block accepts bytes from the first cycle after reset.
`include "length_prefixed_message_type_counter_macros.svh"
module length_prefixed_message_type_counter import lpmtc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte [7:0]
  input  logic                s_axis_tlast,   // stream_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // total_messages [39:0], add_messages [79:40], delete_messages [119:80],
  // cancel_messages [159:120], replace_messages [199:160],
  // unknown_messages [239:200], status [241:240], zero pad above
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  event_t push_ev;
  event_t pop_ev;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_valid;

  lpmtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_axis_tvalid),
    .byte_ready (s_axis_tready),
    .data_byte  (s_axis_tdata),
    .stream_end (s_axis_tlast),
    .q_full     (q_full),
    .ev_push    (push),
    .ev         (push_ev)
  );

  lpmtc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ev (push_ev),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (pop),
    .pop_ev  (pop_ev)
  );

  lpmtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .ev        (pop_ev),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // A request is never written into a full queue
  `LPMTC_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !q_full)
  // A final request taken by the counters loads a result
  `LPMTC_ASSERT_NEXT(a_result_loaded, clk, rst, pop && pop_ev.last, m_axis_tvalid)
  // Status code three is never produced
  `LPMTC_ASSERT_IMPLY(a_status_legal, clk, rst, m_axis_tvalid,
                      m_axis_tdata[6*COUNT_BITS +: STATUS_BITS] != 2'd3)

endmodule
